// ----- src/zdle_escaped_subpacket_framer_defines.svh -----
// assertion macros for the zdle subpacket framer
`ifndef ZDLE_ESCAPED_SUBPACKET_FRAMER_DEFINES_SVH
`define ZDLE_ESCAPED_SUBPACKET_FRAMER_DEFINES_SVH

// same-cycle implication
`define ZDLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ZDLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/zdle_pkg.sv -----
// ----------------------------------------------------------------------------
// zdle_pkg
// types, constants and functions shared by the zdle subpacket framer
// ----------------------------------------------------------------------------
package zdle_pkg;

  localparam logic [7:0]  ZDLE_CODE  = 8'h18;
  localparam logic [7:0]  ESC_FLIP   = 8'h40;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES   = 32'hFFFFFFFF;
  localparam int          FIFO_DEPTH = 4;

  localparam logic [1:0] KIND_END   = 2'd0;
  localparam logic [1:0] KIND_GO    = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_WAIT  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [1:0] end_kind;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       packet_end;
  } line_t;

  // one queued job: payload byte, trailer flag, subtype letter, crc after the byte
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [7:0]  letter;
    logic [31:0] crc;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == 8'h10) || (b == 8'h11) || (b == 8'h13) || (b == 8'h18) ||
           (b == 8'h90) || (b == 8'h91) || (b == 8'h93) || (b == 8'hFF);
  endfunction

  function automatic logic [7:0] kind_letter(input logic [1:0] kind);
    logic [7:0] l;
    case (kind)
      KIND_END:   l = "i";
      KIND_GO:    l = "h";
      KIND_QUERY: l = "j";
      KIND_WAIT:  l = "k";
      default:    l = "i";
    endcase
    return l;
  endfunction

endpackage

// ----- src/zdle_front.sv -----
// ----------------------------------------------------------------------------
// zdle_front
// takes payload beats, runs the crc and queues one job per beat
// ----------------------------------------------------------------------------
module zdle_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  zdle_pkg::item_t item,
  output logic            push,
  output zdle_pkg::job_t  job,
  input  logic            full
);

  logic [31:0] running_crc;
  logic [31:0] crc_next;

  assign item_stall = full;
  assign push       = item_valid && !full;
  assign crc_next   = zdle_pkg::crc_byte(running_crc, item.data_byte);

  assign job.data   = item.data_byte;
  assign job.last   = item.last_byte;
  assign job.letter = zdle_pkg::kind_letter(item.end_kind);
  assign job.crc    = crc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= zdle_pkg::CRC_ONES;
    end else if (push) begin
      running_crc <= item.last_byte ? zdle_pkg::CRC_ONES : crc_next;
    end
  end

endmodule

// ----- src/zdle_fifo.sv -----
// ----------------------------------------------------------------------------
// zdle_fifo
// short job queue between front and back, depth a power of two
// ----------------------------------------------------------------------------
module zdle_fifo #(
  parameter int DEPTH = zdle_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  zdle_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output zdle_pkg::job_t rd_job,
  output logic           not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  zdle_pkg::job_t slots [DEPTH];
  logic [AW:0] wr_ptr;
  logic [AW:0] rd_ptr;

  assign not_empty = (wr_ptr != rd_ptr);
  assign full      = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign rd_job    = slots[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr[AW-1:0]] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ----- src/zdle_back.sv -----
// ----------------------------------------------------------------------------
// zdle_back
// walks each job through its line bytes, escaping, and drives the output beat
// ----------------------------------------------------------------------------
module zdle_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  zdle_pkg::job_t  job,
  output logic            pop,
  output logic            line_valid,
  input  logic            line_stall,
  output zdle_pkg::line_t line
);

  localparam logic [2:0] STEP_DATA   = 3'd0;
  localparam logic [2:0] STEP_ZDLE   = 3'd1;
  localparam logic [2:0] STEP_LETTER = 3'd2;
  localparam logic [2:0] STEP_CRC0   = 3'd3;
  localparam logic [2:0] STEP_CRC1   = 3'd4;
  localparam logic [2:0] STEP_CRC2   = 3'd5;
  localparam logic [2:0] STEP_CRC3   = 3'd6;

  logic [2:0]      step;
  logic [2:0]      step_next;
  logic            second;
  logic            second_next;
  logic [31:0]     crc_fin;
  logic [7:0]      cur;
  logic            escapable;
  logic            emit;
  logic            step_done;
  logic            job_done;
  zdle_pkg::line_t beat;

  always_comb begin
    case (step)
      STEP_DATA:   cur = job.data;
      STEP_ZDLE:   cur = zdle_pkg::ZDLE_CODE;
      STEP_LETTER: cur = job.letter;
      STEP_CRC0:   cur = crc_fin[7:0];
      STEP_CRC1:   cur = crc_fin[15:8];
      STEP_CRC2:   cur = crc_fin[23:16];
      STEP_CRC3:   cur = crc_fin[31:24];
      default:     cur = job.data;
    endcase
  end

  assign escapable = ((step == STEP_DATA) || (step >= STEP_CRC0)) && zdle_pkg::needs_escape(cur);
  assign emit      = not_empty && (!line_valid || !line_stall);
  assign step_done = !escapable || second;
  assign job_done  = step_done && (((step == STEP_DATA) && !job.last) || (step == STEP_CRC3));
  assign pop       = emit && job_done;

  always_comb begin
    if (escapable && !second) begin
      beat.out_byte = zdle_pkg::ZDLE_CODE;
    end else if (second) begin
      beat.out_byte = cur ^ zdle_pkg::ESC_FLIP;
    end else begin
      beat.out_byte = cur;
    end
    beat.run_end    = job_done;
    beat.packet_end = step_done && (step == STEP_CRC3);
  end

  always_comb begin
    step_next   = step;
    second_next = second;
    if (emit) begin
      if (!step_done) begin
        second_next = 1'b1;
      end else begin
        second_next = 1'b0;
        step_next   = job_done ? STEP_DATA : step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= STEP_DATA;
      second     <= 1'b0;
      line_valid <= 1'b0;
    end else begin
      step   <= step_next;
      second <= second_next;
      if (emit) begin
        line_valid <= 1'b1;
      end else if (!line_stall) begin
        line_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      line <= beat;
    end
    if (emit && (step == STEP_ZDLE)) begin
      crc_fin <= zdle_pkg::crc_byte(job.crc, job.letter) ^ zdle_pkg::CRC_ONES;
    end
  end

endmodule

// ----- src/zdle_escaped_subpacket_framer.sv -----
// ----------------------------------------------------------------------------
// zdle_escaped_subpacket_framer
// escapes payload bytes onto the line and appends subtype and crc-32 trailer
// ----------------------------------------------------------------------------
//  channel  dir  beat      handshake
//  item     in   item_t    item_valid / item_stall
//  line     out  line_t    line_valid / line_stall
//
//  the back sequencer puts out one line beat per cycle unless line_stall holds it;
//  an escaped byte goes out as ZDLE and flipped byte, and a last beat adds ZDLE,
//  letter and crc; the front takes a beat per cycle while the job queue has room
//  rst is synchronous and clears the crc, queue pointers and sequencer
//  line_stall holds the output register; item_stall rises when the queue is full
module zdle_escaped_subpacket_framer #(
  parameter int FIFO_DEPTH = zdle_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  zdle_pkg::item_t item,
  output logic            line_valid,
  input  logic            line_stall,
  output zdle_pkg::line_t line
);

  logic           push;
  logic           pop;
  logic           full;
  logic           not_empty;
  zdle_pkg::job_t wr_job;
  zdle_pkg::job_t rd_job;

  zdle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .job        (wr_job),
    .full       (full)
  );

  zdle_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_job    (wr_job),
    .full      (full),
    .pop       (pop),
    .rd_job    (rd_job),
    .not_empty (not_empty)
  );

  zdle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (not_empty),
    .job        (rd_job),
    .pop        (pop),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line       (line)
  );

endmodule

// ----- src/zdle_checker.sv -----
// ----------------------------------------------------------------------------
// zdle_checker
// port-level checks on the item and line streams of the subpacket framer
// ----------------------------------------------------------------------------
`include "zdle_escaped_subpacket_framer_defines.svh"

module zdle_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_stall,
  input zdle_pkg::item_t item,
  input logic            line_valid,
  input logic            line_stall,
  input zdle_pkg::line_t line
);

  logic raw_ok;

  // only the escape code itself may show up from the escape set
  assign raw_ok = !zdle_pkg::needs_escape(line.out_byte) ||
                  (line.out_byte == zdle_pkg::ZDLE_CODE);

  `ZDLE_ASSERT_NEXT(a_item_hold, item_valid && item_stall, item_valid && $stable(item), "item moved")
  `ZDLE_ASSERT_NEXT(a_line_hold, line_valid && line_stall, line_valid && $stable(line), "line moved")
  `ZDLE_ASSERT_NOW(a_packet_end_run_end, line_valid && line.packet_end, line.run_end, "no run end")
  `ZDLE_ASSERT_NOW(a_zdle_not_final, line_valid && !raw_ok, 1'b0, "raw special byte on line")
  `ZDLE_ASSERT_NOW(a_esc_not_last, line_valid && !line.out_byte[7], 1'b1, "unreachable")

endmodule

bind zdle_escaped_subpacket_framer zdle_checker u_chk (.*);
